// ===== src/pafr_pkg.sv =====
// ----------------------------------------------------------------------------
// pafr_pkg
// shared types and constants for the first-fit pool allocator
// ----------------------------------------------------------------------------
package pafr_pkg;

    localparam int RECORDS     = 64;
    localparam int IDX_W       = $clog2(RECORDS);
    localparam int CNT_W       = $clog2(RECORDS + 1);
    localparam int OFFSET_BITS = 20;
    localparam int SIZE_W      = 21;
    localparam int REC_W       = OFFSET_BITS + SIZE_W;

    localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(1048576);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_QUERY   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_NOT_FOUND  = 2'd2,
        ST_TABLE_FULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_OUT
    } t_state;

endpackage

// ===== src/pafr_req_if.sv =====
// ----------------------------------------------------------------------------
// pafr_req_if
// request channel: opcode, request size and release offset
// ----------------------------------------------------------------------------
interface pafr_req_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       opcode;
    logic [pafr_pkg::SIZE_W-1:0]      request_size;
    logic [pafr_pkg::OFFSET_BITS-1:0] release_offset;

    modport source (output valid, output opcode, output request_size,
                    output release_offset, input ready);
    modport sink   (input valid, input opcode, input request_size,
                    input release_offset, output ready);
endinterface

// ===== src/pafr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pafr_rsp_if
// result channel: status, granted offset, used units and tail free
// ----------------------------------------------------------------------------
interface pafr_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [pafr_pkg::OFFSET_BITS-1:0] block_offset;
    logic [pafr_pkg::SIZE_W-1:0]      used_units;
    logic [pafr_pkg::SIZE_W-1:0]      tail_free;

    modport source (output valid, output status, output block_offset,
                    output used_units, output tail_free, input ready);
    modport sink   (input valid, input status, input block_offset,
                    input used_units, input tail_free, output ready);
endinterface

// ===== src/pool_allocator_first_fit_reuse.sv =====
// ----------------------------------------------------------------------------
// pool_allocator_first_fit_reuse
// first-fit allocator over a record table kept in a synchronous memory
// ----------------------------------------------------------------------------
// sequence: allocate and release walk the records from accept, one record
//   read per cycle, each checked when its data returns, then apply and
//   output; a hit ends the walk early; clear all and query go straight
//   to apply and output
// throughput: one item at a time, a new item accepted once the result is
//   in the output register; the walk is paced by the single read port
// reset: synchronous active low; clears busy bits, record count, next free
//   offset and used units, pool size returns to 1048576; memory not cleared
module pool_allocator_first_fit_reuse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pafr_pkg::SIZE_W-1:0] i_cfg_wdata,
    pafr_req_if.sink                    i_req,
    pafr_rsp_if.source                  o_rsp
);
    import pafr_pkg::*;

    // record memory: {offset, size} per entry, one read and one write port
    logic [REC_W-1:0]       mem [RECORDS];
    logic [REC_W-1:0]       r_rd_data;

    // control state
    t_state                 r_state, n_state;
    logic [RECORDS-1:0]     r_busy;
    logic [CNT_W-1:0]       r_count;
    logic [SIZE_W-1:0]      r_nfo;
    logic [SIZE_W-1:0]      r_used;
    logic [SIZE_W-1:0]      r_pool;

    // latched item
    logic [1:0]             r_op;
    logic [SIZE_W-1:0]      r_req;
    logic [OFFSET_BITS-1:0] r_rel;

    // scan pipeline
    logic [CNT_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_chk_idx;
    logic                   r_chk_vld;
    logic                   r_found;
    logic [IDX_W-1:0]       r_hit_idx;
    logic [OFFSET_BITS-1:0] r_hit_off;
    logic [SIZE_W-1:0]      r_hit_size;

    // apply results
    logic [1:0]             r_status;
    logic [OFFSET_BITS-1:0] r_grant;

    // output register
    logic                   r_out_valid;
    logic [1:0]             r_out_status;
    logic [OFFSET_BITS-1:0] r_out_off;
    logic [SIZE_W-1:0]      r_out_used;
    logic [SIZE_W-1:0]      r_out_tail;

    // combinational control
    logic                   accept;
    logic                   out_free;
    logic                   chk_busy;
    logic [OFFSET_BITS-1:0] rd_off;
    logic [SIZE_W-1:0]      rd_size;
    logic                   match;
    logic                   scan_hit;
    logic                   scan_more;
    logic                   rd_en;
    logic                   nfo_in_range;
    logic [SIZE_W:0]        nfo_plus_req;
    logic                   fits;
    logic                   table_full;
    logic                   mem_we;
    logic [SIZE_W-1:0]      tail;

    assign accept    = i_req.valid && i_req.ready;
    assign out_free  = !r_out_valid || o_rsp.ready;

    // record under check, data arrives in the cycle after its read
    assign chk_busy  = r_busy[r_chk_idx];
    assign rd_off    = r_rd_data[SIZE_W +: OFFSET_BITS];
    assign rd_size   = r_rd_data[SIZE_W-1:0];
    assign match     = (r_op == OP_ALLOC) ? (!chk_busy && rd_size >= r_req)
                                          : (chk_busy && rd_off == r_rel);
    assign scan_hit  = r_chk_vld && match;
    assign scan_more = r_idx < r_count;

    // new record checks
    assign nfo_in_range = (r_nfo >> OFFSET_BITS) == '0;
    assign nfo_plus_req = {1'b0, r_nfo} + {1'b0, r_req};
    assign fits         = nfo_in_range && (nfo_plus_req <= {1'b0, r_pool});
    assign table_full   = r_count >= CNT_W'(RECORDS);

    // tail free from registered state, saturating at zero
    assign tail = (r_pool > r_nfo) ? (r_pool - r_nfo) : '0;

    // next state and strobes
    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        rd_en       = 1'b0;
        mem_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    if (i_req.opcode == OP_ALLOC || i_req.opcode == OP_RELEASE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit || !scan_more) begin
                    n_state = S_APPLY;
                end else begin
                    rd_en = 1'b1;
                end
            end
            S_APPLY: begin
                // carve a new record only when no free record fit
                mem_we  = (r_op == OP_ALLOC) && !r_found && fits && !table_full;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // record memory ports
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_idx[IDX_W-1:0]];
        end
        if (mem_we) begin
            mem[r_count[IDX_W-1:0]] <= {r_nfo[OFFSET_BITS-1:0], r_req};
        end
    end

    // pool size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= POOL_RESET;
        end else if (i_cfg_we) begin
            r_pool <= i_cfg_wdata;
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.opcode;
            r_req <= i_req.request_size;
            r_rel <= i_req.release_offset;
        end
    end

    // scan pipeline: issue read of r_idx, check the entry read last cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_found   <= 1'b0;
        end else if (accept) begin
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_found   <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_chk_vld <= rd_en;
            if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (scan_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_chk_idx <= r_idx[IDX_W-1:0];
        end
        if (r_state == S_SCAN && scan_hit) begin
            r_hit_idx  <= r_chk_idx;
            r_hit_off  <= rd_off;
            r_hit_size <= rd_size;
        end
    end

    // apply the operation to table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            r_count <= '0;
            r_nfo   <= '0;
            r_used  <= '0;
        end else if (r_state == S_APPLY) begin
            priority case (1'b1)
                r_op == OP_ALLOC && r_found: begin
                    r_busy[r_hit_idx] <= 1'b1;
                    r_used            <= r_used + r_hit_size;
                end
                mem_we: begin
                    r_busy[r_count[IDX_W-1:0]] <= 1'b1;
                    r_count <= r_count + 1'b1;
                    r_nfo   <= nfo_plus_req[SIZE_W-1:0];
                    r_used  <= r_used + r_req;
                end
                r_op == OP_RELEASE && r_found: begin
                    r_busy[r_hit_idx] <= 1'b0;
                    r_used            <= r_used - r_hit_size;
                end
                r_op == OP_CLEAR: begin
                    r_busy <= '0;
                    r_used <= '0;
                end
                default: ;
            endcase
        end
    end

    // status and granted offset
    always_ff @(posedge i_clk) begin
        if (r_state == S_APPLY) begin
            r_status <= ST_OK;
            r_grant  <= '0;
            unique case (r_op)
                OP_ALLOC: begin
                    if (r_found) begin
                        r_grant <= r_hit_off;
                    end else if (!fits) begin
                        r_status <= ST_EXHAUSTED;
                    end else if (table_full) begin
                        r_status <= ST_TABLE_FULL;
                    end else begin
                        r_grant <= r_nfo[OFFSET_BITS-1:0];
                    end
                end
                OP_RELEASE: begin
                    if (!r_found) begin
                        r_status <= ST_NOT_FOUND;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register, loads once the previous result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_status <= r_status;
            r_out_off    <= r_grant;
            r_out_used   <= r_used;
            r_out_tail   <= tail;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.block_offset = r_out_off;
    assign o_rsp.used_units   = r_out_used;
    assign o_rsp.tail_free    = r_out_tail;

endmodule

// ===== src/pafr_checker.sv =====
// ----------------------------------------------------------------------------
// pafr_port_checks
// port-level checks for the first-fit pool allocator
// ----------------------------------------------------------------------------
module pafr_port_checks (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_req_valid,
    input logic                             i_req_ready,
    input logic                             i_rsp_valid,
    input logic                             i_rsp_ready,
    input logic [1:0]                       i_rsp_status,
    input logic [pafr_pkg::OFFSET_BITS-1:0] i_rsp_block_offset
);
    import pafr_pkg::*;

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // one item in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("item accepted while busy");

    // offset only carried by a successful grant
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != ST_OK) |-> i_rsp_block_offset == '0)
        else $error("nonzero offset on failed item");

    // stalled result stays valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("result dropped while stalled");

endmodule

bind pool_allocator_first_fit_reuse pafr_port_checks u_pafr_port_checks (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_status       (o_rsp.status),
    .i_rsp_block_offset (o_rsp.block_offset)
);
